[src/btwc_pkg.sv]
// ----------------------------------------------------------------------------
// btwc_pkg
// Shared codes, limits and controller/datapath interface types for the
// tunnel wildcard classifier.
// ----------------------------------------------------------------------------
package btwc_pkg;

  localparam int DEF_NUM_SLOTS = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int RES_W         = $clog2(MAX_RESULTS);

  localparam logic [1:0] CMD_REGISTER   = 2'd0;
  localparam logic [1:0] CMD_UNREGISTER = 2'd1;
  localparam logic [1:0] CMD_DISPATCH   = 2'd2;
  localparam logic [1:0] CMD_NOP        = 2'd3;

  localparam logic [2:0] ST_REGISTERED = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_REMOVED    = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_DELIVERED  = 3'd4;
  localparam logic [2:0] ST_DROPPED    = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch the input item, rewind the scan
    logic scan;      // process the slot under the index
    logic inc;       // advance the index
    logic clr;       // rewind the index
    logic fin_load;  // load the single summary result
    logic emit_load; // update the hit slot and load a delivered result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic dispatch;
    logic mask_any;
    logic hit;
    logic out_last;
  } dp_stat_t;

endpackage

[src/btwc_datapath.sv]
// ----------------------------------------------------------------------------
// btwc_datapath
// Slot table, per-slot compare and update logic, id counter and the
// result register.
// ----------------------------------------------------------------------------
module btwc_datapath #(
  parameter int NUM_SLOTS = btwc_pkg::DEF_NUM_SLOTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  btwc_pkg::dp_cmd_t  cmd_i,
  output btwc_pkg::dp_stat_t stat_o,
  input  logic [1:0]         command_i,
  input  logic [47:0]        tunnel_mac_i,
  input  logic [31:0]        src_ip_i,
  input  logic [31:0]        dst_ip_i,
  input  logic [15:0]        src_port_i,
  input  logic [15:0]        dst_port_i,
  input  logic [31:0]        client_tag_i,
  input  logic [31:0]        target_id_i,
  input  logic [15:0]        packet_bytes_i,
  output logic [2:0]         status_o,
  output logic [31:0]        reg_id_o,
  output logic [31:0]        tag_out_o,
  output logic [31:0]        hit_count_o,
  output logic [31:0]        byte_total_o,
  output logic               last_o
);
  import btwc_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // latched item
  logic [1:0]  cmd_q;
  logic [47:0] mac_q;
  logic [31:0] sip_q, dip_q, tag_q, tid_q;
  logic [15:0] sp_q, dp_q, len_q;

  // slot table
  logic [31:0] slot_id_q    [NUM_SLOTS];
  logic [47:0] slot_mac_q   [NUM_SLOTS];
  logic [31:0] slot_sip_q   [NUM_SLOTS];
  logic [31:0] slot_dip_q   [NUM_SLOTS];
  logic [15:0] slot_sp_q    [NUM_SLOTS];
  logic [15:0] slot_dp_q    [NUM_SLOTS];
  logic [31:0] slot_tag_q   [NUM_SLOTS];
  logic [31:0] slot_hits_q  [NUM_SLOTS];
  logic [31:0] slot_bytes_q [NUM_SLOTS];

  logic [IDX_W-1:0]     idx_q;
  logic                 found_q;
  logic [NUM_SLOTS-1:0] mask_q;
  logic [RES_W-1:0]     n_q;
  logic [31:0]          next_id_q, next_id_d;

  logic [2:0]  status_q;
  logic [31:0] reg_id_q, tag_out_q, hits_out_q, bytes_out_q;
  logic        last_q;

  logic [31:0] cur_id, cur_hits_inc, cur_bytes_sum;
  logic        match, do_alloc, do_free, more_above, emit_last;
  logic [NUM_SLOTS-1:0] above;

  // compare the slot under the index
  assign cur_id        = slot_id_q[idx_q];
  assign cur_hits_inc  = slot_hits_q[idx_q] + 32'd1;
  assign cur_bytes_sum = slot_bytes_q[idx_q] + {16'd0, len_q};
  assign match = (cur_id != 32'd0) && (slot_mac_q[idx_q] == mac_q)
              && ((slot_sip_q[idx_q] == 32'd0) || (slot_sip_q[idx_q] == sip_q))
              && ((slot_dip_q[idx_q] == 32'd0) || (slot_dip_q[idx_q] == dip_q))
              && ((slot_sp_q[idx_q]  == 16'd0) || (slot_sp_q[idx_q]  == sp_q))
              && ((slot_dp_q[idx_q]  == 16'd0) || (slot_dp_q[idx_q]  == dp_q));
  assign do_alloc = cmd_i.scan && (cmd_q == CMD_REGISTER) && (cur_id == 32'd0) && !found_q;
  assign do_free  = cmd_i.scan && (cmd_q == CMD_UNREGISTER) && (tid_q != 32'd0)
                 && (cur_id == tid_q);
  assign next_id_d = (next_id_q == 32'hFFFF_FFFF) ? 32'd1 : next_id_q + 32'd1;

  // later matches and the result cap decide the last flag
  assign above      = (mask_q >> idx_q) >> 1;
  assign more_above = |above;
  assign emit_last  = !more_above || (n_q == RES_W'(MAX_RESULTS - 1));

  // control state and slot ids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      found_q   <= 1'b0;
      mask_q    <= '0;
      n_q       <= '0;
      next_id_q <= 32'd1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_id_q[i] <= 32'd0;
      end
    end else begin
      if (cmd_i.load || cmd_i.clr) begin
        idx_q <= '0;
      end else if (cmd_i.inc) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.load) begin
        found_q <= 1'b0;
        mask_q  <= '0;
        n_q     <= '0;
      end
      if (do_alloc) begin
        slot_id_q[idx_q] <= next_id_q;
        next_id_q        <= next_id_d;
        found_q          <= 1'b1;
      end
      if (do_free) begin
        slot_id_q[idx_q] <= 32'd0;
        found_q          <= 1'b1;
      end
      if (cmd_i.scan && (cmd_q == CMD_DISPATCH)) begin
        mask_q[idx_q] <= match;
      end
      if (cmd_i.emit_load) begin
        n_q <= n_q + RES_W'(1);
      end
    end
  end

  // payload: latched item, slot contents, result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      mac_q <= tunnel_mac_i;
      sip_q <= src_ip_i;
      dip_q <= dst_ip_i;
      sp_q  <= src_port_i;
      dp_q  <= dst_port_i;
      tag_q <= client_tag_i;
      tid_q <= target_id_i;
      len_q <= packet_bytes_i;
    end
    if (do_alloc) begin
      slot_mac_q[idx_q]   <= mac_q;
      slot_sip_q[idx_q]   <= sip_q;
      slot_dip_q[idx_q]   <= dip_q;
      slot_sp_q[idx_q]    <= sp_q;
      slot_dp_q[idx_q]    <= dp_q;
      slot_tag_q[idx_q]   <= tag_q;
      slot_hits_q[idx_q]  <= 32'd0;
      slot_bytes_q[idx_q] <= 32'd0;
      status_q    <= ST_REGISTERED;
      reg_id_q    <= next_id_q;
      tag_out_q   <= tag_q;
      hits_out_q  <= 32'd0;
      bytes_out_q <= 32'd0;
      last_q      <= 1'b1;
    end
    if (cmd_i.fin_load) begin
      tag_out_q   <= 32'd0;
      hits_out_q  <= 32'd0;
      bytes_out_q <= 32'd0;
      last_q      <= 1'b1;
      case (cmd_q)
        CMD_REGISTER: begin
          // a successful allocation already loaded its result
          if (!found_q) begin
            status_q  <= ST_FULL;
            reg_id_q  <= 32'd0;
          end else begin
            tag_out_q <= tag_q;
          end
        end
        CMD_UNREGISTER: begin
          status_q <= found_q ? ST_REMOVED : ST_NOT_FOUND;
          reg_id_q <= found_q ? tid_q : 32'd0;
        end
        default: begin
          status_q <= ST_DROPPED;
          reg_id_q <= 32'd0;
        end
      endcase
    end
    if (cmd_i.emit_load) begin
      slot_hits_q[idx_q]  <= cur_hits_inc;
      slot_bytes_q[idx_q] <= cur_bytes_sum;
      status_q    <= ST_DELIVERED;
      reg_id_q    <= cur_id;
      tag_out_q   <= slot_tag_q[idx_q];
      hits_out_q  <= cur_hits_inc;
      bytes_out_q <= cur_bytes_sum;
      last_q      <= emit_last;
    end
  end

  assign stat_o.scan_last = (idx_q == IDX_W'(NUM_SLOTS - 1));
  assign stat_o.dispatch  = (cmd_q == CMD_DISPATCH);
  assign stat_o.mask_any  = |mask_q;
  assign stat_o.hit       = mask_q[idx_q];
  assign stat_o.out_last  = last_q;

  assign status_o     = status_q;
  assign reg_id_o     = reg_id_q;
  assign tag_out_o    = tag_out_q;
  assign hit_count_o  = hits_out_q;
  assign byte_total_o = bytes_out_q;
  assign last_o       = last_q;

endmodule

[src/btwc_ctrl.sv]
// ----------------------------------------------------------------------------
// btwc_ctrl
// Sequencer: accept an item, scan the table, then emit one or more results;
// a no-op item is taken with no result.
module btwc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output btwc_pkg::dp_cmd_t  cmd_o,
  input  btwc_pkg::dp_stat_t stat_i
);
  import btwc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (command_i != CMD_NOP)) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.inc = 1'b1;
        end
      end
      S_FIN: begin
        if (stat_i.dispatch && stat_i.mask_any) begin
          cmd_o.clr = 1'b1;
          state_d   = S_EMIT;
        end else begin
          cmd_o.fin_load = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_EMIT: begin
        if (stat_i.hit) begin
          cmd_o.emit_load = 1'b1;
          state_d         = S_OUT;
        end else begin
          cmd_o.inc = 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (stat_i.out_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.inc = 1'b1;
            state_d   = S_EMIT;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input and output sides open together");
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && stat_i.out_last) |=> in_ready_o)
    else $error("not idle after final transfer");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (command_i != CMD_NOP)) |=> !in_ready_o)
    else $error("ready right after accepting work");
`endif

endmodule

[src/basic_tunnel_wildcard_classifier_unit.sv]
// ----------------------------------------------------------------------------
// basic_tunnel_wildcard_classifier_unit
// Tunnel client table: register, unregister and wildcard dispatch lookup.
// ----------------------------------------------------------------------------
// After an input transfer the controller scans every slot, then loads one
// summary result; a dispatch with matches instead walks the slots again and
// loads one result per hit, waiting for each output transfer before the next.
// Items are taken one at a time; command 3 is taken with no result.
// Reset (rst_ni low, async): all slots free, next id 1, controller idle.
module basic_tunnel_wildcard_classifier_unit #(
  parameter int NUM_SLOTS = btwc_pkg::DEF_NUM_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [47:0] tunnel_mac_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [31:0] client_tag_i,
  input  logic [31:0] target_id_i,
  input  logic [15:0] packet_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] reg_id_o,
  output logic [31:0] tag_out_o,
  output logic [31:0] hit_count_o,
  output logic [31:0] byte_total_o,
  output logic        last_o
);
  import btwc_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  btwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  btwc_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .command_i      (command_i),
    .tunnel_mac_i   (tunnel_mac_i),
    .src_ip_i       (src_ip_i),
    .dst_ip_i       (dst_ip_i),
    .src_port_i     (src_port_i),
    .dst_port_i     (dst_port_i),
    .client_tag_i   (client_tag_i),
    .target_id_i    (target_id_i),
    .packet_bytes_i (packet_bytes_i),
    .status_o       (status_o),
    .reg_id_o       (reg_id_o),
    .tag_out_o      (tag_out_o),
    .hit_count_o    (hit_count_o),
    .byte_total_o   (byte_total_o),
    .last_o         (last_o)
  );

endmodule
